>>> rtl/lbm_pkg.sv
// Shared types, widths and helpers for the D2Q9 BGK collision pipeline.
// No dependencies; every other file of the block imports this package.
package lbm_pkg;

  localparam int NCH = 9;             // populations per node
  localparam int DW = 24;             // Q4.20 field width
  localparam int QF = 20;             // fraction bits
  localparam int RW = 28;             // exact density sum
  localparam int MW = 27;             // exact first moments
  localparam int NW = MW - 1 + QF;    // dividend magnitude width
  localparam int DVW = 27;            // divisor (positive density) width
  localparam int QW = 24;             // quotient bits kept
  localparam int DIV_STAGES = 12;
  localparam int DIV_STEPS = QW / DIV_STAGES;
  localparam int PW = 36;             // 2 * equilibrium polynomial
  localparam int TW = 44;             // rho * polynomial after rounding
  localparam int MAGW = 48;           // magnitude for the divide by nine
  localparam int OW = 15;             // relaxation rate width
  localparam logic [OW-1:0] OMEGA_RESET = 15'd16384;

  // Weight 16, 4 or 1 (over 72) as a left shift, per channel.
  localparam int WSHIFT [NCH] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

  localparam logic signed [DW-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [DW-1:0] SMIN = 24'sh800000;

  typedef logic signed [DW-1:0] pop_t;
  typedef pop_t [NCH-1:0] pops_t;

  typedef struct packed {
    pops_t                f;
    logic signed [RW-1:0] rho;
    logic                 rpos;
    logic                 negx;
    logic                 negy;
  } side_t;

  typedef struct packed {
    side_t side;
    pop_t  ux;
    pop_t  uy;
  } pass_t;

  function automatic pop_t sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return SMAX;
    if (v < -64'sd8388608) return SMIN;
    return v[DW-1:0];
  endfunction

endpackage

>>> rtl/lbm_mom.sv
// Moment stages: density and first moments, then the unsigned dividend and
// divisor for the velocity divider. Depends on lbm_pkg.
module lbm_mom
  import lbm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pops_t          in_pops,
  output logic           out_valid,
  input  logic           out_ready,
  output side_t          out_side,
  output logic [NW-1:0]  out_numx,
  output logic [NW-1:0]  out_numy,
  output logic [DVW-1:0] out_den
);

  logic                 a_valid, b_valid, a_en, b_en;
  pops_t                a_pops;
  logic signed [RW-1:0] a_rho, rho_sum;
  logic signed [MW-1:0] a_mx, a_my, mx_sum, my_sum, mag_x, mag_y;

  assign b_en = !b_valid || out_ready;
  assign a_en = !a_valid || b_en;
  assign in_ready = a_en;
  assign out_valid = b_valid;

  always_comb begin
    rho_sum = '0;
    for (int i = 0; i < NCH; i++) begin
      rho_sum = rho_sum + RW'($signed(in_pops[i]));
    end
    mx_sum = MW'($signed(in_pops[1])) + MW'($signed(in_pops[5])) + MW'($signed(in_pops[8]))
           - MW'($signed(in_pops[3])) - MW'($signed(in_pops[6])) - MW'($signed(in_pops[7]));
    my_sum = MW'($signed(in_pops[2])) + MW'($signed(in_pops[5])) + MW'($signed(in_pops[6]))
           - MW'($signed(in_pops[4])) - MW'($signed(in_pops[7])) - MW'($signed(in_pops[8]));
    mag_x = a_mx[MW-1] ? -a_mx : a_mx;
    mag_y = a_my[MW-1] ? -a_my : a_my;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= in_valid;
      if (b_en) b_valid <= a_valid;
    end
    if (a_en) begin
      a_pops <= in_pops;
      a_rho <= rho_sum;
      a_mx <= mx_sum;
      a_my <= my_sum;
    end
    if (b_en) begin
      out_side.f <= a_pops;
      out_side.rho <= a_rho;
      out_side.rpos <= a_rho > 0;
      out_side.negx <= a_mx[MW-1];
      out_side.negy <= a_my[MW-1];
      out_numx <= {mag_x[MW-2:0], {QF{1'b0}}};
      out_numy <= {mag_y[MW-2:0], {QF{1'b0}}};
      // A non-positive density gives zero velocity later; divide by one meanwhile.
      out_den <= (a_rho > 0) ? a_rho[DVW-1:0] : DVW'(1);
    end
  end

endmodule

>>> rtl/lbm_vdiv.sv
// Pipelined restoring divider for both velocity components, two quotient
// bits per stage, with an overflow flag for quotients beyond 24 bits.
// Depends on lbm_pkg.
module lbm_vdiv
  import lbm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  side_t          in_side,
  input  logic [NW-1:0]  in_numx,
  input  logic [NW-1:0]  in_numy,
  input  logic [DVW-1:0] in_den,
  output logic           out_valid,
  input  logic           out_ready,
  output side_t          out_side,
  output logic [QW-1:0]  out_qx,
  output logic [QW-1:0]  out_qy,
  output logic           out_ovfx,
  output logic           out_ovfy
);

  typedef struct packed {
    side_t          side;
    logic [DVW-1:0] den;
    logic [DVW-1:0] rx;
    logic [DVW-1:0] ry;
    logic [QW-1:0]  lowx;
    logic [QW-1:0]  lowy;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qy;
    logic           ovfx;
    logic           ovfy;
  } dstage_t;

  dstage_t               st [DIV_STAGES+1];
  dstage_t               nx [DIV_STAGES+1];
  logic [DIV_STAGES:0]   v;
  logic [DIV_STAGES:0]   vprev;
  logic [DIV_STAGES+1:0] en;
  logic [DVW:0]          sx, sy;

  // Returns {quotient bit, new remainder}.
  function automatic logic [DVW:0] dstep(input logic [DVW-1:0] r, input logic b,
                                         input logic [DVW-1:0] d);
    logic [DVW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {1'b1, t[DVW-1:0]};
    end
    return {1'b0, t[DVW-1:0]};
  endfunction

  always_comb begin
    en[DIV_STAGES+1] = out_ready;
    for (int k = DIV_STAGES; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign vprev = {v[DIV_STAGES-1:0], in_valid};

  always_comb begin
    sx = '0;
    sy = '0;
    nx[0].side = in_side;
    nx[0].den = in_den;
    nx[0].rx = DVW'(in_numx[NW-1:QW]);
    nx[0].ry = DVW'(in_numy[NW-1:QW]);
    nx[0].lowx = in_numx[QW-1:0];
    nx[0].lowy = in_numy[QW-1:0];
    nx[0].qx = '0;
    nx[0].qy = '0;
    // The high part already reaching the divisor means a quotient of 2^24 or more.
    nx[0].ovfx = DVW'(in_numx[NW-1:QW]) >= in_den;
    nx[0].ovfy = DVW'(in_numy[NW-1:QW]) >= in_den;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      nx[k] = st[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        sx = dstep(nx[k].rx, nx[k].lowx[QW-1], nx[k].den);
        sy = dstep(nx[k].ry, nx[k].lowy[QW-1], nx[k].den);
        nx[k].rx = sx[DVW-1:0];
        nx[k].ry = sy[DVW-1:0];
        nx[k].qx = {nx[k].qx[QW-2:0], sx[DVW]};
        nx[k].qy = {nx[k].qy[QW-2:0], sy[DVW]};
        nx[k].lowx = {nx[k].lowx[QW-2:0], 1'b0};
        nx[k].lowy = {nx[k].lowy[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        if (en[k]) v[k] <= vprev[k];
      end
    end
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

  assign out_valid = v[DIV_STAGES];
  assign out_side = st[DIV_STAGES].side;
  assign out_qx = st[DIV_STAGES].qx;
  assign out_qy = st[DIV_STAGES].qy;
  assign out_ovfx = st[DIV_STAGES].ovfx;
  assign out_ovfy = st[DIV_STAGES].ovfy;

`ifndef ASSERT_OFF
  // Without overflow the final remainders must lie below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v[DIV_STAGES] && !st[DIV_STAGES].ovfx && !st[DIV_STAGES].ovfy |->
      (st[DIV_STAGES].rx < st[DIV_STAGES].den) && (st[DIV_STAGES].ry < st[DIV_STAGES].den))
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> rtl/lbm_eq.sv
// Equilibrium stages: saturated velocity, squares, the per-channel
// polynomial and its product with density, split into partial products.
// Depends on lbm_pkg.
module lbm_eq
  import lbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  side_t                in_side,
  input  logic [QW-1:0]        in_qx,
  input  logic [QW-1:0]        in_qy,
  input  logic                 in_ovfx,
  input  logic                 in_ovfy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pass_t                out_pass,
  output logic signed [TW-1:0] out_t [NCH]
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] v, vprev;
  logic [NSTG:0]   en;

  side_t s1, s2, s3, s4;
  pop_t  e1_ux, e1_uy, e2_ux, e2_uy, e3_ux, e3_uy, e4_ux, e4_uy;
  logic signed [DW:0]      e1_sp, e1_sm, e2_sp, e2_sm;
  logic signed [2*DW-1:0]  e2_px, e2_py;
  logic signed [2*DW+1:0]  e2_pp, e2_pm;
  logic signed [29:0]      sqx, sqy, sqp, sqm, usq;
  logic signed [DW:0]      cu [NCH];
  logic signed [29:0]      cu2 [NCH];
  logic signed [PW-1:0]    poly [NCH];
  logic signed [PW-1:0]    e3_poly [NCH];
  logic signed [RW+18:0]   e4_plo [NCH];
  logic signed [RW+17:0]   e4_phi [NCH];
  logic signed [63:0]      psum [NCH];

  function automatic pop_t vel(input logic [QW-1:0] q, input logic ovf, input logic neg,
                               input logic rpos);
    if (!rpos) return '0;
    if (!neg) return (ovf || q[QW-1]) ? SMAX : $signed(q);
    if (ovf || q > 24'h800000) return SMIN;
    // A magnitude of exactly 2^23 wraps to the most negative value, as it should.
    return pop_t'(0) - $signed(q);
  endfunction

  function automatic logic signed [29:0] rq20(input logic signed [2*DW+1:0] p);
    logic signed [2*DW+1:0] s;
    s = p + 50'sd524288;
    return 30'(s >>> QF);
  endfunction

  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign vprev = {v[NSTG-2:0], in_valid};
  assign out_valid = v[NSTG-1];

  always_comb begin
    sqx = rq20(50'(e2_px));
    sqy = rq20(50'(e2_py));
    sqp = rq20(e2_pp);
    sqm = rq20(e2_pm);
    usq = sqx + sqy;
    cu[0] = '0;
    cu[1] = 25'(e2_ux);
    cu[2] = 25'(e2_uy);
    cu[3] = -25'(e2_ux);
    cu[4] = -25'(e2_uy);
    cu[5] = e2_sp;
    cu[6] = -e2_sm;
    cu[7] = -e2_sp;
    cu[8] = e2_sm;
    cu2[0] = '0;
    cu2[1] = sqx;
    cu2[3] = sqx;
    cu2[2] = sqy;
    cu2[4] = sqy;
    cu2[5] = sqp;
    cu2[7] = sqp;
    cu2[6] = sqm;
    cu2[8] = sqm;
    for (int i = 0; i < NCH; i++) begin
      poly[i] = 36'sd2097152 + PW'(cu[i]) * 36'sd6 + PW'(cu2[i]) * 36'sd9
              - PW'(usq) * 36'sd3;
      psum[i] = (64'(e4_phi[i]) <<< 18) + 64'(e4_plo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v[k] <= vprev[k];
      end
    end
    if (en[0]) begin
      s1 <= in_side;
      e1_ux <= vel(in_qx, in_ovfx, in_side.negx, in_side.rpos);
      e1_uy <= vel(in_qy, in_ovfy, in_side.negy, in_side.rpos);
    end
    if (en[1]) begin
      s2 <= s1;
      e2_ux <= e1_ux;
      e2_uy <= e1_uy;
      e2_sp <= e1_sp;
      e2_sm <= e1_sm;
      e2_px <= 48'(e1_ux) * 48'(e1_ux);
      e2_py <= 48'(e1_uy) * 48'(e1_uy);
      e2_pp <= 50'(e1_sp) * 50'(e1_sp);
      e2_pm <= 50'(e1_sm) * 50'(e1_sm);
    end
    if (en[2]) begin
      s3 <= s2;
      e3_ux <= e2_ux;
      e3_uy <= e2_uy;
      for (int i = 0; i < NCH; i++) e3_poly[i] <= poly[i];
    end
    if (en[3]) begin
      s4 <= s3;
      e4_ux <= e3_ux;
      e4_uy <= e3_uy;
      for (int i = 0; i < NCH; i++) begin
        e4_plo[i] <= 47'(s3.rho) * 47'($signed({1'b0, e3_poly[i][17:0]}));
        e4_phi[i] <= 46'(s3.rho) * 46'($signed(e3_poly[i][PW-1:18]));
      end
    end
    if (en[4]) begin
      out_pass.side <= s4;
      out_pass.ux <= e4_ux;
      out_pass.uy <= e4_uy;
      for (int i = 0; i < NCH; i++) begin
        out_t[i] <= TW'((psum[i] + 64'sd524288) >>> QF);
      end
    end
  end

  assign e1_sp = 25'(e1_ux) + 25'(e1_uy);
  assign e1_sm = 25'(e1_ux) - 25'(e1_uy);

endmodule

>>> rtl/lbm_rlx.sv
// Relaxation stages: equilibrium by the weight over 72 (a shift and a
// digit-serial divide by nine), then the BGK update and saturation.
// Depends on lbm_pkg.
module lbm_rlx
  import lbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [OW-1:0]        omega,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pass_t                in_pass,
  input  logic signed [TW-1:0] in_t [NCH],
  output logic                 out_valid,
  input  logic                 out_ready,
  output pop_t                 out_post [NCH],
  output pop_t                 out_density,
  output pop_t                 out_ux,
  output pop_t                 out_uy
);

  localparam int DSTG = 3;
  localparam int DPS = MAGW / 4 / DSTG;
  localparam int NSTG = DSTG + 3;
  localparam int XW = TW + 5;
  localparam int PRW = TW + OW + 2;

  typedef struct packed {
    logic [MAGW-1:0] m;
    logic [3:0]      r;
    logic [MAGW-1:0] q;
    logic            neg;
  } dq_t;

  logic [NSTG-1:0] v, vprev;
  logic [NSTG:0]   en;

  dq_t [NCH-1:0] dq [DSTG+1];
  dq_t [NCH-1:0] dq_nx [DSTG+1];
  pass_t         pv [NSTG-1];
  logic signed [PRW-1:0] prod [NCH];
  logic signed [PRW-1:0] prod_nx [NCH];
  logic signed [XW-1:0]  x [NCH];
  logic signed [XW-1:0]  y [NCH];
  logic signed [TW-1:0]  feq [NCH];
  logic signed [TW:0]    dif [NCH];
  logic signed [63:0]    post [NCH];
  logic [7:0]            dg;

  // Returns {quotient digit, remainder} of {r, dig} / 9.
  function automatic logic [7:0] d9(input logic [3:0] r, input logic [3:0] dig);
    logic [7:0]  vv;
    logic [13:0] p;
    logic [3:0]  q;
    vv = {r, dig};
    p = 14'(vv) * 14'd57;
    q = p[12:9];
    return {q, 4'(vv - 8'(q) * 8'd9)};
  endfunction

  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign vprev = {v[NSTG-2:0], in_valid};
  assign out_valid = v[NSTG-1];

  always_comb begin
    dg = '0;
    for (int i = 0; i < NCH; i++) begin
      // Round to nearest over 72: floor((t * w + 36) / 8) / 9, floored.
      x[i] = (XW'(in_t[i]) <<< WSHIFT[i]) + XW'(36);
      y[i] = x[i] >>> 3;
      dq_nx[0][i].neg = y[i] < 0;
      dq_nx[0][i].m = (y[i] < 0) ? MAGW'(XW'(8) - y[i]) : MAGW'(y[i]);
      dq_nx[0][i].r = '0;
      dq_nx[0][i].q = '0;
    end
    for (int k = 1; k <= DSTG; k++) begin
      dq_nx[k] = dq[k-1];
      for (int i = 0; i < NCH; i++) begin
        for (int j = 0; j < DPS; j++) begin
          dg = d9(dq_nx[k][i].r, dq_nx[k][i].m[MAGW-1 -: 4]);
          dq_nx[k][i].r = dg[3:0];
          dq_nx[k][i].q = {dq_nx[k][i].q[MAGW-5:0], dg[7:4]};
          dq_nx[k][i].m = {dq_nx[k][i].m[MAGW-5:0], 4'b0};
        end
      end
    end
    for (int i = 0; i < NCH; i++) begin
      feq[i] = dq[DSTG][i].neg ? -$signed(TW'(dq[DSTG][i].q)) : $signed(TW'(dq[DSTG][i].q));
      dif[i] = (TW+1)'($signed(pv[DSTG].side.f[i])) - (TW+1)'(feq[i]);
      prod_nx[i] = PRW'(dif[i]) * PRW'($signed({1'b0, omega}));
      post[i] = 64'($signed(pv[DSTG+1].side.f[i])) - ((64'(prod[i]) + 64'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v[k] <= vprev[k];
      end
    end
    for (int k = 0; k <= DSTG; k++) begin
      if (en[k]) dq[k] <= dq_nx[k];
    end
    if (en[0]) pv[0] <= in_pass;
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) pv[k] <= pv[k-1];
    end
    if (en[DSTG+1]) begin
      for (int i = 0; i < NCH; i++) prod[i] <= prod_nx[i];
    end
    if (en[NSTG-1]) begin
      for (int i = 0; i < NCH; i++) out_post[i] <= sat24(post[i]);
      out_density <= sat24(64'(pv[NSTG-2].side.rho));
      out_ux <= pv[NSTG-2].ux;
      out_uy <= pv[NSTG-2].uy;
    end
  end

endmodule

>>> rtl/lbm_d2q9_node_collision_unit.sv
// D2Q9 BGK collision of one lattice node per item, fully pipelined.
// Throughput one item per cycle while the sink is ready, set by the 13-stage
// velocity divider and the pipelined partial-product multipliers. Every
// stage stalls independently, so empty stages keep filling while a result
// waits. Synchronous active-high reset empties the pipeline and sets the
// relaxation rate to 1.0 (Q1.14).
module lbm_d2q9_node_collision_unit
  import lbm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // pop_rest, pop_east, pop_north, pop_west, pop_south, pop_northeast,
  // pop_northwest, pop_southwest, pop_southeast (24 bits each, from bit 0)
  input  logic [215:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // post_rest .. post_southeast, density, velocity_x, velocity_y
  // (24 bits each, from bit 0)
  output logic [287:0]  m_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [OW-1:0] cfg_data
);

  logic [OW-1:0] omega;

  logic           mom_valid, mom_ready, div_valid, div_ready, eq_valid, eq_ready;
  side_t          mom_side, div_side;
  logic [NW-1:0]  mom_numx, mom_numy;
  logic [DVW-1:0] mom_den;
  logic [QW-1:0]  div_qx, div_qy;
  logic           div_ovfx, div_ovfy;
  pass_t          eq_pass;
  logic signed [TW-1:0] eq_t [NCH];
  pop_t           post [NCH];
  pop_t           density, vel_x, vel_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= OMEGA_RESET;
    end else if (cfg_valid) begin
      omega <= cfg_data;
    end
  end

  lbm_mom u_mom (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_pops(pops_t'(s_tdata)),
    .out_valid(mom_valid), .out_ready(mom_ready), .out_side(mom_side),
    .out_numx(mom_numx), .out_numy(mom_numy), .out_den(mom_den)
  );

  lbm_vdiv u_vdiv (
    .clk(clk), .rst(rst),
    .in_valid(mom_valid), .in_ready(mom_ready), .in_side(mom_side),
    .in_numx(mom_numx), .in_numy(mom_numy), .in_den(mom_den),
    .out_valid(div_valid), .out_ready(div_ready), .out_side(div_side),
    .out_qx(div_qx), .out_qy(div_qy), .out_ovfx(div_ovfx), .out_ovfy(div_ovfy)
  );

  lbm_eq u_eq (
    .clk(clk), .rst(rst),
    .in_valid(div_valid), .in_ready(div_ready), .in_side(div_side),
    .in_qx(div_qx), .in_qy(div_qy), .in_ovfx(div_ovfx), .in_ovfy(div_ovfy),
    .out_valid(eq_valid), .out_ready(eq_ready), .out_pass(eq_pass), .out_t(eq_t)
  );

  lbm_rlx u_rlx (
    .clk(clk), .rst(rst), .omega(omega),
    .in_valid(eq_valid), .in_ready(eq_ready), .in_pass(eq_pass), .in_t(eq_t),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_post(post),
    .out_density(density), .out_ux(vel_x), .out_uy(vel_y)
  );

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < NCH; i++) begin
      m_tdata[i*DW +: DW] = post[i];
    end
    m_tdata[NCH*DW +: DW] = density;
    m_tdata[(NCH+1)*DW +: DW] = vel_x;
    m_tdata[(NCH+2)*DW +: DW] = vel_y;
  end

`ifndef ASSERT_OFF
  // With the sink ready every stage can move, so the input side must be ready.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  a_zero_velocity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ($signed(density) <= 0) |-> (vel_x == '0) && (vel_y == '0))
    else $error("velocity not zero for non-positive density");
`endif

endmodule
